@@ hdl/sorted_key_value_table_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_key_value_table_assert.svh
// Assertion macros shared by the sorted key-value table modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SKV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/skvt_pkg.sv @@
// ----------------------------------------------------------------------------
// skvt_pkg
// Types and constants of the sorted key-value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int DefCapacity = 16;
  localparam int MaxResults  = 16;
  localparam int KeyW        = 32;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_RANGE  = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic CFG_DESCENDING = 1'b0;
  localparam logic CFG_NULL_VALUE = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KeyW-1:0]   key;
    logic [KeyW-1:0]   value;
    logic [KeyW-1:0]   range_low;
    logic [KeyW-1:0]   range_high;
    logic              bad_range;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [KeyW-1:0] key_out;
    logic [KeyW-1:0] value_out;
    logic [4:0]      entry_count;
    logic            table_empty;
    logic            last;
  } res_t;

  // signed compare as unsigned after flipping the sign bit
  function automatic logic key_lt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    key_lt = (a ^ {1'b1, {(KeyW-1){1'b0}}}) < (b ^ {1'b1, {(KeyW-1){1'b0}}});
  endfunction

endpackage

@@ hdl/sorted_key_value_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key-value table kept sorted by key, with insert, lookup, delete and range.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (opcode, key, value, range bounds) and results
// leave on m_axis; m_axis_tlast marks the final result of a request.
// A two-entry command queue decouples intake from the cell array.
// Insert, lookup and delete: one result, registered once the request has
// passed the queue; the cell array takes no new request until that result is
// loaded. It compares all keys at once and shifts as the result is loaded.
// Range query: the array is scanned one cell per cycle while the output is
// free, and a request emits up to 16 results.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written by the user while
// idle, not enforced by the block: index 0 descending_order, index 1 null_value.
// Reset empties the table, sets ascending order and null_value to -1.
// When m_axis_tready is low the result holds; the queue fills and then
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
  parameter int CAPACITY = skvt_pkg::DefCapacity
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], key[33:2], value[65:34], range_low[97:66], range_high[129:98]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], key_out[33:2], value_out[65:34], entry_count[70:66],
  // table_empty[71]
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import skvt_pkg::*;

  logic        descending;
  logic [31:0] null_value;
  cmd_t        s_cmd, q_cmd;
  logic        q_valid, q_ready;
  res_t        m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      null_value <= '1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DESCENDING) descending <= cfg_data[0];
      else null_value <= cfg_data;
    end
  end

  always_comb begin
    s_cmd.opcode     = s_axis_tdata[1:0];
    s_cmd.key        = s_axis_tdata[33:2];
    s_cmd.value      = s_axis_tdata[65:34];
    s_cmd.range_low  = s_axis_tdata[97:66];
    s_cmd.range_high = s_axis_tdata[129:98];
    s_cmd.bad_range  = 1'b0;
  end

  skvt_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_cmd(s_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  skvt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .descending(descending), .null_value(null_value),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(m_res)
  );

  assign m_axis_tdata = {m_res.table_empty, m_res.entry_count, m_res.value_out,
                         m_res.key_out, m_res.status};
  assign m_axis_tlast = m_res.last;
endmodule

@@ hdl/skvt_front.sv @@
// ----------------------------------------------------------------------------
// skvt_front
// Accepts requests, flags empty ranges and queues commands for the back end.
// ----------------------------------------------------------------------------
module skvt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  skvt_pkg::cmd_t     s_cmd,
  output logic               q_valid,
  input  logic               q_ready,
  output skvt_pkg::cmd_t     q_cmd
);
  import skvt_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic            push;
  logic            pop;
  cmd_t            cls;

  assign s_tready = (fill != (PtrW+1)'(QueueDepth));
  assign q_valid  = (fill != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_comb begin
    cls = s_cmd;
    cls.bad_range = key_lt(s_cmd.range_high, s_cmd.range_low);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `include "sorted_key_value_table_assert.svh"
  `SKV_ASSERT_IMP(a_fill_range, 1'b1, fill <= (PtrW+1)'(QueueDepth))
  `SKV_ASSERT_NEXT(a_push_grows, push && !pop, fill == $past(fill) + 1'b1)
  `SKV_ASSERT_NEXT(a_pop_shrinks, pop && !push, fill == $past(fill) - 1'b1)
endmodule

@@ hdl/skvt_back.sv @@
// ----------------------------------------------------------------------------
// skvt_back
// Cell array of keys and values: parallel match and order compare, shift on
// insert and delete, range scan one cell per cycle while the output is free.
// ----------------------------------------------------------------------------
module skvt_back #(
  parameter int CAPACITY = skvt_pkg::DefCapacity
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  descending,
  input  logic [31:0]           null_value,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  skvt_pkg::cmd_t        q_cmd,
  output logic                  m_valid,
  input  logic                  m_ready,
  output skvt_pkg::res_t        m_res
);
  import skvt_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int NW   = $clog2(MaxResults + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [KeyW-1:0] keys [CAPACITY];
  logic [KeyW-1:0] vals [CAPACITY];
  logic [CntW-1:0] used;
  logic [1:0]      state;
  cmd_t            cur;
  logic [CntW-1:0] scan;
  logic [NW-1:0]   nres;
  logic            have;
  res_t            held;

  logic [CAPACITY-1:0] live, hit, precede;
  logic [IdxW-1:0]     hit_idx, ins_idx;
  logic                found, any_before;
  logic [KeyW-1:0]     hit_val;

  always_comb begin
    hit_idx = '0;
    ins_idx = used[IdxW-1:0];
    found = 1'b0;
    any_before = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]    = (CntW'(i) < used);
      hit[i]     = live[i] && (keys[i] == cur.key);
      precede[i] = live[i] && (descending ? key_lt(keys[i], cur.key)
                                          : key_lt(cur.key, keys[i]));
    end
    for (int i = CAPACITY-1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (precede[i]) begin
        any_before = 1'b1;
        ins_idx = IdxW'(i);
      end
    end
    hit_val = vals[hit_idx];
  end

  logic [IdxW-1:0] sidx;
  logic            in_range, scan_done, out_free;
  assign sidx      = scan[IdxW-1:0];
  assign in_range  = !cur.bad_range && !key_lt(keys[sidx], cur.range_low) &&
                     !key_lt(cur.range_high, keys[sidx]);
  assign scan_done = (scan >= used) || (nres == NW'(MaxResults));
  assign out_free  = !m_valid || m_ready;
  assign q_ready   = (state == S_IDLE);

  res_t r;
  always_comb begin
    r = '0;
    r.key_out = cur.key;
    r.value_out = null_value;
    r.status = ST_ABSENT;
    r.last = 1'b1;
    case (cur.opcode)
      OP_INSERT: begin
        if (found) begin
          r.status = ST_FOUND;
          r.value_out = hit_val;
        end else if (used == CntW'(CAPACITY)) begin
          r.status = ST_FULL;
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        if (found) begin
          r.status = ST_FOUND;
          r.value_out = hit_val;
        end
      end
      default: ;
    endcase
  end

  logic [CntW-1:0] used_after;
  always_comb begin
    used_after = used;
    if (cur.opcode == OP_INSERT && !found && used != CntW'(CAPACITY))
      used_after = used + 1'b1;
    else if (cur.opcode == OP_DELETE && found)
      used_after = used - 1'b1;
  end

  // matched pair waits in held until the next match or the end of the scan
  res_t held_next;
  logic take_held;
  assign take_held = (state == S_SCAN) && out_free && !scan_done && in_range;

  always_comb begin
    held_next.status      = ST_FOUND;
    held_next.key_out     = keys[sidx];
    held_next.value_out   = vals[sidx];
    held_next.entry_count = 5'(used);
    held_next.table_empty = (used == '0);
    held_next.last        = 1'b0;
  end

  res_t res_next;
  logic load_res;
  always_comb begin
    load_res = 1'b0;
    res_next = r;
    res_next.entry_count = 5'(used_after);
    res_next.table_empty = (used_after == '0);
    case (state)
      S_OUT: load_res = out_free;
      S_SCAN: begin
        if (out_free) begin
          if (scan_done) begin
            load_res = 1'b1;
            if (have) begin
              res_next = held;
              res_next.last = 1'b1;
            end
          end else if (in_range) begin
            load_res = have;
            res_next = held;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free && cur.opcode == OP_INSERT) begin
      if (found) begin
        vals[hit_idx] <= cur.value;
      end else if (used != CntW'(CAPACITY)) begin
        for (int i = 1; i < CAPACITY; i++) begin
          if (IdxW'(i) > ins_idx && any_before) begin
            keys[i] <= keys[i-1];
            vals[i] <= vals[i-1];
          end
        end
        keys[ins_idx] <= cur.key;
        vals[ins_idx] <= cur.value;
      end
    end
    if (state == S_OUT && out_free && cur.opcode == OP_DELETE && found) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (IdxW'(i) >= hit_idx) begin
          keys[i] <= keys[i+1];
          vals[i] <= vals[i+1];
        end
      end
    end
    if (q_valid && q_ready) cur <= q_cmd;
    if (load_res) m_res <= res_next;
    if (take_held) held <= held_next;
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      m_valid <= 1'b0;
      have    <= 1'b0;
      scan    <= '0;
      nres    <= '0;
    end else begin
      m_valid <= load_res || (m_valid && !m_ready);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= (q_cmd.opcode == OP_RANGE) ? S_SCAN : S_OUT;
            scan  <= '0;
            nres  <= '0;
            have  <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_free) begin
            used <= used_after;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (scan_done) begin
              state <= S_IDLE;
            end else begin
              scan <= scan + 1'b1;
              if (in_range) begin
                have <= 1'b1;
                nres <= nres + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "sorted_key_value_table_assert.svh"
  `SKV_ASSERT_IMP(a_used_cap, 1'b1, used <= CntW'(CAPACITY))
  `SKV_ASSERT_IMP(a_take_idle, q_valid && q_ready, state == S_IDLE)
  `SKV_ASSERT_NEXT(a_hold_out, m_valid && !m_ready, m_valid && $stable(m_res))
endmodule

@@ test/tb_sorted_key_value_table.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_key_value_table
// Self-checking bench for the sorted key-value table.
// ----------------------------------------------------------------------------
// Requests are driven with random gaps and the results are taken with random
// stalls. A scoreboard keeps its own copy of the table and predicts the
// results of every accepted request, which are checked field by field in
// order. Order and null value are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table;
  import skvt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [4:0]  entry_count;
    logic        table_empty;
    logic        last;
  } kv_result_t;

  class kv_table_scoreboard;
    logic [31:0] keys[16];
    logic [31:0] vals[16];
    int unsigned used;
    bit          descending;
    logic [31:0] null_val;
    kv_result_t  pending[$];
    int          errors;

    function new();
      used = 0;
      descending = 0;
      null_val = 32'hFFFF_FFFF;
      errors = 0;
    endfunction

    function bit precedes(logic [31:0] a, logic [31:0] b);
      if (descending) begin
        return $signed(a) > $signed(b);
      end
      return $signed(a) < $signed(b);
    endfunction

    function void push(logic [1:0] st, logic [31:0] k, logic [31:0] v, bit lst);
      kv_result_t r;
      r.status = st;
      r.key_out = k;
      r.value_out = v;
      r.entry_count = used[4:0];
      r.table_empty = (used == 0);
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                               logic [31:0] lo, logic [31:0] hi);
      int pos;
      int at;
      int n;
      logic [31:0] old;
      pos = -1;
      for (int i = 0; i < used; i++) begin
        if (pos < 0 && keys[i] == k) pos = i;
      end
      case (op)
        OP_INSERT: begin
          if (pos >= 0) begin
            old = vals[pos];
            vals[pos] = v;
            push(ST_FOUND, k, old, 1);
          end else if (used >= 16) begin
            push(ST_FULL, k, null_val, 1);
          end else begin
            at = used;
            for (int i = used - 1; i >= 0; i--) begin
              if (precedes(k, keys[i])) at = i;
            end
            for (int i = used; i > at; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[at] = k;
            vals[at] = v;
            used++;
            push(ST_ABSENT, k, null_val, 1);
          end
        end
        OP_LOOKUP: begin
          if (pos >= 0) push(ST_FOUND, k, vals[pos], 1);
          else push(ST_ABSENT, k, null_val, 1);
        end
        OP_DELETE: begin
          if (pos >= 0) begin
            old = vals[pos];
            for (int i = pos; i + 1 < used; i++) begin
              keys[i] = keys[i+1];
              vals[i] = vals[i+1];
            end
            used--;
            push(ST_FOUND, k, old, 1);
          end else begin
            push(ST_ABSENT, k, null_val, 1);
          end
        end
        default: begin
          n = 0;
          for (int i = 0; i < used; i++) begin
            if ($signed(keys[i]) >= $signed(lo) && $signed(keys[i]) <= $signed(hi)) begin
              push(ST_FOUND, keys[i], vals[i], 0);
              n++;
            end
          end
          if (n == 0) push(ST_ABSENT, k, null_val, 1);
          else pending[$].last = 1;
        end
      endcase
    endfunction

    function void check_result(kv_result_t got);
      kv_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
      if (got.key_out !== exp.key_out)
        $display("%0t key_out exp %h got %h", $time, exp.key_out, got.key_out);
      if (got.value_out !== exp.value_out)
        $display("%0t value_out exp %h got %h", $time, exp.value_out, got.value_out);
      if (got.entry_count !== exp.entry_count)
        $display("%0t entry_count exp %0d got %0d", $time, exp.entry_count,
                 got.entry_count);
      if (got.table_empty !== exp.table_empty)
        $display("%0t table_empty exp %0d got %0d", $time, exp.table_empty,
                 got.table_empty);
      if (got.last !== exp.last)
        $display("%0t last exp %0d got %0d", $time, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we = 0;
  logic         cfg_index = CFG_DESCENDING;
  logic [31:0]  cfg_data = '0;

  kv_table_scoreboard board = new();
  logic [31:0] key_pool[8];

  sorted_key_value_table dut (.*);

  always #1 clk = ~clk;

  // tvalid stays up after a handshake until the next request or an idle phase
  task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                              logic [31:0] lo, logic [31:0] hi);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, hi, lo, v, k, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(op, k, v, lo, hi);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_DESCENDING) board.descending = d[0];
    else board.null_val = d;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_phase(int count);
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      a = pick_key();
      b = pick_key();
      if ($urandom_range(0, 9) == 0) send_request(OP_RANGE, $urandom, 0, a, b);
      else if ($signed(a) <= $signed(b)) send_request(2'($urandom_range(0, 3)),
                                                      pick_key(), $urandom, a, b);
      else send_request(2'($urandom_range(0, 3)), pick_key(), $urandom, b, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_result({m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                            m_axis_tdata[70:66], m_axis_tdata[71], m_axis_tlast});
    end
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    key_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'hFFFF_FFFF, 5, 32'hFFFF_FFF0, 100};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(OP_RANGE, 7, 0, 0, 100);
    send_request(OP_LOOKUP, 32'h8000_0000, 0, 0, 0);
    send_request(OP_DELETE, 3, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_request(OP_INSERT, (i == 16) ? 32'h8000_0000 : 32'h7FFF_FFF0 - i * 7,
                   $urandom, 0, 0);
    send_request(OP_INSERT, 32'h7FFF_FFF0, 32'h1234_5678, 0, 0);
    send_request(OP_RANGE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_RANGE, 0, 0, 5, 1);
    send_request(OP_LOOKUP, 32'h7FFF_FFE9, 0, 0, 0);
    send_request(OP_DELETE, 32'h7FFF_FFE9, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_request(OP_DELETE, 32'h7FFF_FFF0 - i * 7, 0, 0, 0);
    write_reg(CFG_DESCENDING, 1);
    write_reg(CFG_NULL_VALUE, 32'h8000_0000);
    random_phase(76);
    write_reg(CFG_DESCENDING, 0);
    write_reg(CFG_NULL_VALUE, 32'h7FFF_FFFF);
    random_phase(76);
    write_reg(CFG_DESCENDING, 1);
    write_reg(CFG_NULL_VALUE, 0);
    random_phase(76);
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("PASS sorted_key_value_table");
    else $display("FAIL sorted_key_value_table");
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL sorted_key_value_table");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/skvt_pkg.sv
hdl/skvt_front.sv
hdl/skvt_back.sv
hdl/sorted_key_value_table.sv
test/tb_sorted_key_value_table.sv
